>>> hdl/crdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package crdr_pkg;

    localparam int ROW_CAPACITY_DEF = 64;
    localparam int INDEX_BITS_DEF   = 24;
    localparam int DBL_BITS         = 64;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_MISSING  = 2'd1;
    localparam logic [1:0] STATUS_NOT_POS  = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

    localparam logic [DBL_BITS-1:0] DBL_POS_INF = 64'h7FF0_0000_0000_0000;

endpackage
`default_nettype wire

>>> hdl/csr_row_diagonal_reciprocal.sv
// entry: an entry that does not end a row is taken into the row store unless it is full
// row end: binary search by repeated halving, then the reciprocal unit:
// normalization (subnormal divisor only), restoring division and
// rounding; the result then passes through the result register
// throughput: entries 1 per cycle while entry_stall is low, one row end at a time
// reset: asynchronous active low, clears control state, count and overflow
`timescale 1ns / 1ps
`default_nettype none
module csr_row_diagonal_reciprocal #(
    parameter int ROW_CAPACITY = crdr_pkg::ROW_CAPACITY_DEF,
    parameter int INDEX_BITS   = crdr_pkg::INDEX_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           entry_valid,
    output logic                                entry_stall,
    input  wire logic [INDEX_BITS-1:0]          row_number,
    input  wire logic [INDEX_BITS-1:0]          column_number,
    input  wire logic [crdr_pkg::DBL_BITS-1:0]  entry_bits,
    input  wire logic                           row_empty,
    input  wire logic                           last_entry,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic [INDEX_BITS-1:0]               result_row,
    output logic [crdr_pkg::DBL_BITS-1:0]       inverse_bits,
    output logic [1:0]                          status
);
    import crdr_pkg::*;

    localparam int AW = (ROW_CAPACITY > 1) ? $clog2(ROW_CAPACITY) : 1;
    localparam int CW = $clog2(ROW_CAPACITY + 1);

    typedef enum logic [4:0] {
        T_LOAD = 5'b00001,
        T_SRCH = 5'b00010,
        T_CMP  = 5'b00100,
        T_FIN  = 5'b01000,
        T_DIV  = 5'b10000
    } tstate_t;

    tstate_t                state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    logic [AW-1:0]          lo_reg, lo_next;
    logic [AW-1:0]          hi_reg, hi_next;
    logic [INDEX_BITS-1:0]  row_reg, row_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [INDEX_BITS-1:0]  out_row_reg, out_row_next;
    logic [DBL_BITS-1:0]    out_inv_reg, out_inv_next;
    logic [1:0]             out_st_reg, out_st_next;

    // row store
    logic [INDEX_BITS-1:0]  column_store [ROW_CAPACITY];
    logic [DBL_BITS-1:0]    value_store  [ROW_CAPACITY];
    logic [INDEX_BITS-1:0]  col_rd_reg;
    logic [DBL_BITS-1:0]    val_rd_reg;
    logic [AW-1:0]          rd_addr;
    logic                   wr_en;

    logic                   take;
    logic                   full;
    logic [AW:0]            mid_sum;
    logic [AW-1:0]          mid;
    logic                   d_nan;
    logic                   d_inf;
    logic                   d_not_pos;

    logic                   rcp_start;
    logic                   rcp_done;
    logic [DBL_BITS-1:0]    rcp_bits;

    assign entry_stall = (state_reg != T_LOAD) || out_valid_reg;
    assign take        = entry_valid && !entry_stall;
    assign full        = (count_reg == CW'(ROW_CAPACITY));
    assign wr_en       = take && !row_empty && !full;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[AW:1];
    assign rd_addr = (lo_reg < hi_reg) ? mid : lo_reg;

    // classification of the candidate diagonal
    assign d_nan     = (val_rd_reg[62:52] == '1) && (val_rd_reg[51:0] != '0);
    assign d_inf     = (val_rd_reg[62:0] == {11'h7FF, 52'd0}) && !val_rd_reg[63];
    assign d_not_pos = val_rd_reg[63] || d_nan || (val_rd_reg[62:0] == '0);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_row_next   = out_row_reg;
        out_inv_next   = out_inv_reg;
        out_st_next    = out_st_reg;
        rcp_start      = 1'b0;
        case (state_reg)
            T_LOAD:
            begin
                if (take)
                begin
                    if (row_empty)
                    begin
                        // empty row drops anything held and reports missing
                        out_valid_next = 1'b1;
                        out_row_next   = row_number;
                        out_inv_next   = '0;
                        out_st_next    = STATUS_MISSING;
                        count_next     = '0;
                        ovf_next       = 1'b0;
                    end
                    else if (last_entry)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        row_next   = row_number;
                        if (ovf_reg || full)
                        begin
                            out_valid_next = 1'b1;
                            out_row_next   = row_number;
                            out_inv_next   = '0;
                            out_st_next    = STATUS_OVERFLOW;
                        end
                        else
                        begin
                            lo_next    = '0;
                            hi_next    = count_reg[AW-1:0];
                            state_next = T_SRCH;
                        end
                    end
                    else if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            T_SRCH:
            begin
                // read issued at rd_addr this cycle
                state_next = (lo_reg < hi_reg) ? T_CMP : T_FIN;
            end
            T_CMP:
            begin
                // lower-bound halving step
                if (row_reg <= col_rd_reg)
                begin
                    hi_next = mid;
                end
                else
                begin
                    lo_next = mid + AW'(1);
                end
                state_next = T_SRCH;
            end
            T_FIN:
            begin
                if (col_rd_reg != row_reg)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = row_reg;
                    out_inv_next   = '0;
                    out_st_next    = STATUS_MISSING;
                    state_next     = T_LOAD;
                end
                else if (d_not_pos)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = row_reg;
                    out_inv_next   = '0;
                    out_st_next    = STATUS_NOT_POS;
                    state_next     = T_LOAD;
                end
                else if (d_inf)
                begin
                    // one over infinity is plus zero
                    out_valid_next = 1'b1;
                    out_row_next   = row_reg;
                    out_inv_next   = '0;
                    out_st_next    = STATUS_OK;
                    state_next     = T_LOAD;
                end
                else
                begin
                    rcp_start  = 1'b1;
                    state_next = T_DIV;
                end
            end
            T_DIV:
            begin
                if (rcp_done)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = row_reg;
                    out_inv_next   = rcp_bits;
                    out_st_next    = STATUS_OK;
                    state_next     = T_LOAD;
                end
            end
            default:
            begin
                state_next = T_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        row_reg     <= row_next;
        out_row_reg <= out_row_next;
        out_inv_reg <= out_inv_next;
        out_st_reg  <= out_st_next;
    end

    // row store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            column_store[count_reg[AW-1:0]] <= column_number;
            value_store[count_reg[AW-1:0]]  <= entry_bits;
        end
        col_rd_reg <= column_store[rd_addr];
        val_rd_reg <= value_store[rd_addr];
    end

    crdr_recip u_recip (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (rcp_start),
        .d_bits (val_rd_reg),
        .done   (rcp_done),
        .q_bits (rcp_bits)
    );

    assign result_valid = out_valid_reg;
    assign result_row   = out_row_reg;
    assign inverse_bits = out_inv_reg;
    assign status       = out_st_reg;

    // entries are never taken while a result waits
    assert property (@(posedge clk) disable iff (!rst_n) result_valid |-> entry_stall)
        else $error("entry taken while result pending");

    // error results carry zero bits
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status != STATUS_OK)) |-> (inverse_bits == '0))
        else $error("nonzero inverse on error status");

    // fill count stays within the store
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ROW_CAPACITY))
        else $error("entry count beyond capacity");

    // reciprocal is started only after the search lands
    assert property (@(posedge clk) disable iff (!rst_n)
        rcp_start |=> (state_reg == T_DIV))
        else $error("reciprocal start out of sequence");

endmodule
`default_nettype wire

>>> hdl/crdr_recip.sv
`timescale 1ns / 1ps
`default_nettype none
module crdr_recip (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [crdr_pkg::DBL_BITS-1:0]  d_bits,
    output logic                                done,
    output logic [crdr_pkg::DBL_BITS-1:0]       q_bits
);
    import crdr_pkg::*;

    typedef enum logic [3:0] {
        R_IDLE = 4'b0001,
        R_NORM = 4'b0010,
        R_DIV  = 4'b0100,
        R_RND  = 4'b1000
    } rstate_t;

    rstate_t            state_reg, state_next;
    logic [52:0]        m_reg, m_next;
    logic signed [12:0] e_reg, e_next;
    logic [54:0]        rem_reg, rem_next;
    logic [56:0]        q_reg, q_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [63:0]        res_reg, res_next;
    logic               done_reg, done_next;

    logic [54:0]        diff;
    logic               qb;
    logic               sticky;
    logic [55:0]        sig;
    logic signed [12:0] er;
    logic signed [12:0] biased;
    logic signed [12:0] sh;
    logic [55:0]        v;
    logic [55:0]        lost_mask;
    logic [10:0]        exp_field;
    logic               rup;

    assign diff = rem_reg - {2'b00, m_reg};
    assign qb   = ~diff[54];

    // rounding datapath, used in R_RND
    always_comb
    begin
        sticky = (rem_reg != '0);
        if (q_reg[56])
        begin
            sig = {q_reg[56:4], q_reg[3], q_reg[2], q_reg[1] | q_reg[0] | sticky};
            er  = -e_reg;
        end
        else
        begin
            sig = {q_reg[55:3], q_reg[2], q_reg[1], q_reg[0] | sticky};
            er  = -e_reg - 13'sd1;
        end
        biased = er + 13'sd1023;
        sh     = 13'sd1 - biased;
        if (biased > 13'sd0)
        begin
            v         = sig;
            exp_field = biased[10:0];
            lost_mask = '0;
        end
        else
        begin
            lost_mask = (56'd1 << sh[5:0]) - 56'd1;
            v         = sig >> sh[5:0];
            v[0]      = v[0] | ((sig & lost_mask) != '0);
            exp_field = '0;
        end
        rup = v[2] & (v[1] | v[0] | v[3]);
    end

    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        e_next     = e_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        case (state_reg)
            R_IDLE:
            begin
                if (start)
                begin
                    if (d_bits[62:52] == '0)
                    begin
                        m_next     = {1'b0, d_bits[51:0]};
                        e_next     = -13'sd1022;
                        state_next = R_NORM;
                    end
                    else
                    begin
                        m_next     = {1'b1, d_bits[51:0]};
                        e_next     = $signed({2'b00, d_bits[62:52]}) - 13'sd1023;
                        rem_next   = 55'd1 << 52;
                        q_next     = '0;
                        cnt_next   = '0;
                        state_next = R_DIV;
                    end
                end
            end
            R_NORM:
            begin
                // subnormal divisor: one bit of normalization a cycle
                if (m_reg[52])
                begin
                    rem_next   = 55'd1 << 52;
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = R_DIV;
                end
                else
                begin
                    m_next = {m_reg[51:0], 1'b0};
                    e_next = e_reg - 13'sd1;
                end
            end
            R_DIV:
            begin
                // restoring division, one quotient bit a cycle
                rem_next = {(qb ? diff[53:0] : rem_reg[53:0]), 1'b0};
                q_next   = {q_reg[55:0], qb};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd56)
                begin
                    state_next = R_RND;
                end
            end
            R_RND:
            begin
                if (biased >= 13'sd2047)
                begin
                    res_next = DBL_POS_INF;
                end
                else
                begin
                    res_next = {1'b0, exp_field, v[54:3]} + {63'd0, rup};
                end
                done_next  = 1'b1;
                state_next = R_IDLE;
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg   <= m_next;
        e_reg   <= e_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign q_bits = res_reg;

endmodule
`default_nettype wire

>>> tb/sv/csr_row_diagonal_reciprocal_tb.sv
`timescale 1ns / 1ps
module csr_row_diagonal_reciprocal_tb;
    import crdr_pkg::*;

    localparam int CAP = ROW_CAPACITY_DEF;
    localparam int IW  = INDEX_BITS_DEF;

    typedef struct packed {
        logic [IW-1:0]       row;
        logic [DBL_BITS-1:0] inv;
        logic [1:0]          st;
    } diag_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                entry_valid = 1'b0;
    logic                entry_stall;
    logic [IW-1:0]       row_number = '0;
    logic [IW-1:0]       column_number = '0;
    logic [DBL_BITS-1:0] entry_bits = '0;
    logic                row_empty = 1'b0;
    logic                last_entry = 1'b0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [IW-1:0]       result_row;
    logic [DBL_BITS-1:0] inverse_bits;
    logic [1:0]          status;

    csr_row_diagonal_reciprocal DUT (
        .clk(clk), .rst_n(rst_n),
        .entry_valid(entry_valid), .entry_stall(entry_stall),
        .row_number(row_number), .column_number(column_number),
        .entry_bits(entry_bits), .row_empty(row_empty), .last_entry(last_entry),
        .result_valid(result_valid), .result_stall(result_stall),
        .result_row(result_row), .inverse_bits(inverse_bits), .status(status)
    );

    always #2 clk = ~clk;

    // predictor copy of the row buffer
    logic [IW-1:0]       held_cols [CAP];
    logic [DBL_BITS-1:0] held_vals [CAP];
    int                  held_count = 0;
    bit                  held_overflow = 0;
    diag_result_t        pending_diag [$];

    int  errors = 0;
    bit  gaps_on = 1;       // random idling on both sides
    int  hold_cycles = 0;   // long receiver hold-off, counted down below

    // positive: sign clear, not zero, not NaN (+inf counts)
    function automatic bit dbl_positive(input logic [63:0] b);
        return !b[63] && (b[62:0] != '0) && !(b[62:52] == 11'h7FF && b[51:0] != '0);
    endfunction

    // expected outcome of one accepted transfer
    task automatic predict_entry(input logic [IW-1:0] r, input logic [IW-1:0] c,
                                 input logic [63:0] b, input bit e, input bit l);
        diag_result_t res;
        int lo, hi, mid;
        res.row = r;
        res.inv = '0;
        if (e) begin
            res.st = STATUS_MISSING;
            pending_diag.push_back(res);
            held_count = 0;
            held_overflow = 0;
            return;
        end
        if (held_count < CAP) begin
            held_cols[held_count] = c;
            held_vals[held_count] = b;
            held_count++;
        end else
            held_overflow = 1;
        if (!l)
            return;
        if (held_overflow)
            res.st = STATUS_OVERFLOW;
        else begin
            // lower-bound search over the order stored
            lo = 0;
            hi = held_count - 1;
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (r <= held_cols[mid])
                    hi = mid;
                else
                    lo = mid + 1;
            end
            if (held_cols[lo] != r)
                res.st = STATUS_MISSING;
            else if (!dbl_positive(held_vals[lo]))
                res.st = STATUS_NOT_POS;
            else begin
                res.st = STATUS_OK;
                res.inv = $realtobits(1.0 / $bitstoreal(held_vals[lo]));
            end
        end
        pending_diag.push_back(res);
        held_count = 0;
        held_overflow = 0;
    endtask

    // one entry transfer, then maybe an idle burst
    task automatic send_entry(input logic [IW-1:0] r, input logic [IW-1:0] c,
                              input logic [63:0] b, input bit e, input bit l);
        bit stalled;
        entry_valid <= 1'b1;
        row_number <= r;
        column_number <= c;
        entry_bits <= b;
        row_empty <= e;
        last_entry <= l;
        do begin
            @(negedge clk);
            stalled = entry_stall;
            @(posedge clk);
        end while (stalled);
        predict_entry(r, c, b, e, l);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            entry_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // receiver: stall generation and result checking
    int stall_left = 0;
    always @(posedge clk) begin
        diag_result_t want;
        if (result_valid && !result_stall) begin
            if (pending_diag.size() == 0) begin
                $display("%0t: unexpected result row=%h inv=%h status=%0d",
                         $time, result_row, inverse_bits, status);
                errors++;
            end else begin
                want = pending_diag.pop_front();
                if (result_row !== want.row) begin
                    $display("%0t: result_row expected %h actual %h",
                             $time, want.row, result_row);
                    errors++;
                end
                if (inverse_bits !== want.inv) begin
                    $display("%0t: inverse_bits expected %h actual %h",
                             $time, want.inv, inverse_bits);
                    errors++;
                end
                if (status !== want.st) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.st, status);
                    errors++;
                end
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            result_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            result_stall <= 1'b1;
        end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 14);
            result_stall <= 1'b1;
        end else
            result_stall <= 1'b0;
    end

    function automatic logic [63:0] pick_value(input int kind);
        logic [63:0] b;
        b = {$urandom, $urandom};
        case (kind)
            0: b[63] = 1'b1;                                   // negative
            1: b = {$urandom_range(0, 1) == 1, 63'd0};         // plus or minus zero
            2: b = {1'b0, 11'h7FF, 20'($urandom) | 20'h1, $urandom}; // NaN
            3: b = {1'b0, 11'h000, b[51:0]};                    // subnormal
            4: b = 64'h7FF0_0000_0000_0000;                     // +inf
            default: b[63] = 1'b0;                              // positive normal
        endcase
        return b;
    endfunction

    // one row: sorted random columns, diagonal present by chance
    task automatic send_row(input logic [IW-1:0] r, input int len, input bit with_diag,
                            input int kind);
        logic [IW-1:0] cols [$];
        logic [63:0] b;
        for (int i = 0; i < len; i++)
            cols.push_back($urandom_range(0, 1) ? IW'($urandom)
                                                : IW'(r + $urandom_range(0, 6) - 3));
        if (with_diag)
            cols[$urandom_range(0, len - 1)] = r;
        cols.sort();
        for (int i = 0; i < len; i++) begin
            b = (cols[i] == r) ? pick_value(kind) : {$urandom, $urandom};
            send_entry($urandom_range(0, 3) == 0 ? IW'($urandom) : r, cols[i], b, 1'b0,
                       i == len - 1);
        end
    endtask

    task automatic test_directed;
        send_entry('0, '0, 64'h3FF0_0000_0000_0000, 0, 1);         // 1.0 on row 0
        send_entry('1, '1, 64'h4000_0000_0000_0000, 0, 1);         // max index
        send_entry(24'h5, 24'h5, 64'h0000_0000_0000_0001, 0, 1);   // tiny, inverts to inf
        send_entry(24'h6, 24'h6, 64'hBFF0_0000_0000_0000, 0, 1);   // negative
        send_entry(24'h7, 24'h7, 64'h0, 0, 1);                     // zero
        send_entry(24'h8, 24'h8, 64'h7FF8_0000_0000_0000, 0, 1);   // NaN
        send_entry(24'h9, 24'h9, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1);   // negative NaN
        send_entry(24'hA, 24'hB, 64'h3FF0_0000_0000_0000, 0, 1);   // diagonal missing
        send_entry(24'hA, 24'h2, '1, 0, 0);                        // held then dropped
        send_entry(24'hC, '1, '1, 1, 1);                           // empty row
        send_entry(24'h3, 24'h9, 64'h4010_0000_0000_0000, 0, 0);   // unsorted row
        send_entry(24'h3, 24'h3, 64'h4010_0000_0000_0000, 0, 0);
        send_entry(24'h3, 24'h1, 64'h4020_0000_0000_0000, 0, 1);
        send_entry(24'h4, 24'h4, 64'h7FF0_0000_0000_0000, 0, 1);   // +inf diagonal
        send_entry(24'h2, 24'h2, 64'h000F_FFFF_FFFF_FFFF, 0, 1);   // largest subnormal
    endtask

    task automatic test_overflow;
        send_row(24'h40, CAP, 1, 5);                  // exactly full, fine
        send_row(24'h41, CAP + 1, 1, 5);              // one past capacity
        send_row(24'h42, CAP + 6, 1, 5);
    endtask

    task automatic test_backpressure;
        hold_cycles = 600;
        for (int i = 0; i < 12; i++)
            send_row(IW'($urandom_range(0, 50)), $urandom_range(1, 3), 1, 5);
    endtask

    task automatic test_random(input int n_items);
        int sent, len;
        logic [IW-1:0] r;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 1) ? IW'($urandom) : IW'($urandom_range(0, 40));
            if ($urandom_range(0, 11) == 0) begin
                send_entry(r, IW'($urandom), {$urandom, $urandom}, 1,
                           $urandom_range(0, 1) == 1);
                sent++;
            end else begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 68)
                                                   : $urandom_range(1, 8);
                send_row(r, len, $urandom_range(0, 5) != 0, $urandom_range(0, 9));
                sent += len;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_overflow();
        test_backpressure();
        test_random(500);
        gaps_on = 0;
        test_random(120);
        entry_valid <= 1'b0;
        while (pending_diag.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0 && held_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

>>> files.f
hdl/crdr_pkg.sv
hdl/crdr_recip.sv
hdl/csr_row_diagonal_reciprocal.sv
tb/sv/csr_row_diagonal_reciprocal_tb.sv
